// ----- hdl/md5_pkg.sv -----
package md5_pkg;

	// What an accepted input item asks the back part to do.
	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_LAST,
		KIND_BYTE_LAST
	} md5_kind_t;

	typedef struct packed {
		logic [7:0] data;
		md5_kind_t  kind;
	} md5_item_t;

	// The four MD5 working or chaining words.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} md5_work_t;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW = $clog2(QueueDepth);

	localparam md5_work_t ChainInit = '{
		a: 32'h67452301,
		b: 32'hefcdab89,
		c: 32'h98badcfe,
		d: 32'h10325476
	};

	localparam logic [31:0] RoundK [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// Indexed by the round group and the low two bits of the round.
	localparam logic [4:0] RoundS [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] t;
		t = {x, x} << s;
		return t[63:32];
	endfunction

	// Message word used by a round; all arithmetic is modulo 16.
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] lo;
		lo = rnd[3:0];
		case (rnd[5:4])
			2'd0: return lo;
			2'd1: return 4'((lo << 2) + lo + 4'd1);
			2'd2: return 4'((lo << 1) + lo + 4'd5);
			default: return 4'((lo << 3) - lo);
		endcase
	endfunction

endpackage

// ----- hdl/md5_front.sv -----
module md5_front import md5_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_data,
	input  logic       in_present,
	input  logic       in_last,
	output logic       item_valid,
	input  logic       item_ready,
	output md5_item_t  item
);

	md5_item_t             queue_q [QueueDepth];
	logic [QueuePtrW-1:0]  wr_ptr_q;
	logic [QueuePtrW-1:0]  rd_ptr_q;
	logic [QueuePtrW:0]    count_q;
	md5_item_t             in_item;
	logic                  push;
	logic                  pop;

	always_comb begin
		in_item.data = in_data;
		if (in_present && in_last) begin
			in_item.kind = KIND_BYTE_LAST;
		end else if (in_present) begin
			in_item.kind = KIND_BYTE;
		end else begin
			in_item.kind = KIND_LAST;
		end
	end

	assign in_ready = (count_q != (QueuePtrW + 1)'(QueueDepth));
	// An item with neither a byte nor the last mark changes nothing and is dropped here.
	assign push = in_valid && in_ready && (in_present || in_last);
	assign item_valid = (count_q != '0);
	assign pop = item_valid && item_ready;
	assign item = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

// ----- hdl/md5_round.sv -----
module md5_round import md5_pkg::*; (
	input  logic [5:0]  rnd,
	input  md5_work_t   cur,
	input  logic [31:0] msg_word,
	output logic [3:0]  msg_idx,
	output md5_work_t   nxt
);

	logic [31:0] f;
	logic [31:0] sum;

	always_comb begin
		case (rnd[5:4])
			2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
			2'd1: f = (cur.b & cur.d) | (cur.c & ~cur.d);
			2'd2: f = cur.b ^ cur.c ^ cur.d;
			default: f = cur.c ^ (cur.b | ~cur.d);
		endcase
	end

	assign msg_idx = msg_index(rnd);
	assign sum = cur.a + f + RoundK[rnd] + msg_word;

	assign nxt.a = cur.d;
	assign nxt.b = cur.b + rotl32(sum, RoundS[{rnd[5:4], rnd[1:0]}]);
	assign nxt.c = cur.b;
	assign nxt.d = cur.c;

endmodule

// ----- hdl/md5_back.sv -----
module md5_back import md5_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  md5_item_t  item,
	output logic       digest_valid,
	input  logic       digest_ready,
	output logic [7:0] digest_byte,
	output logic       digest_last
);

	typedef enum logic [2:0] {
		ST_ABSORB,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t      state_q;
	state_t      ret_q;
	logic [60:0] count_q;
	md5_work_t   chain_q;
	md5_work_t   work_q;
	logic [5:0]  rnd_q;
	logic [3:0]  out_idx_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [31:0] block_q [16];

	logic [5:0]  pos;
	logic [3:0]  pad_w;
	logic [1:0]  lane;
	logic [31:0] keep;
	logic [31:0] pad_word;
	logic        pad_two;
	logic [63:0] len_bits;
	logic [3:0]  msg_idx;
	md5_work_t   work_next;
	logic [31:0] out_word;
	logic        take;
	logic        load_out;

	md5_round u_round (
		.rnd      (rnd_q),
		.cur      (work_q),
		.msg_word (block_q[msg_idx]),
		.msg_idx  (msg_idx),
		.nxt      (work_next)
	);

	assign pos = count_q[5:0];
	assign pad_w = pos[5:2];
	assign lane = pos[1:0];
	assign pad_two = (pos[5:3] == 3'b111);
	assign len_bits = {count_q, 3'b000};

	always_comb begin
		case (lane)
			2'd0: keep = 32'h0000_0000;
			2'd1: keep = 32'h0000_00ff;
			2'd2: keep = 32'h0000_ffff;
			default: keep = 32'h00ff_ffff;
		endcase
		pad_word = (block_q[pad_w] & keep) | (32'h0000_0080 << {lane, 3'b000});
	end

	always_comb begin
		case (out_idx_q[3:2])
			2'd0: out_word = chain_q.a;
			2'd1: out_word = chain_q.b;
			2'd2: out_word = chain_q.c;
			default: out_word = chain_q.d;
		endcase
	end

	assign item_ready = (state_q == ST_ABSORB);
	assign take = item_valid && item_ready;
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || digest_ready);

	assign digest_valid = out_valid_q;
	assign digest_byte = out_byte_q;
	assign digest_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ABSORB;
			ret_q <= ST_ABSORB;
			count_q <= '0;
			chain_q <= ChainInit;
			rnd_q <= '0;
			out_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (digest_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ABSORB: begin
					if (take) begin
						case (item.kind)
							KIND_BYTE: begin
								count_q <= count_q + 61'd1;
								if (pos == 6'd63) begin
									state_q <= ST_ROUND;
									ret_q <= ST_ABSORB;
									rnd_q <= '0;
								end
							end
							KIND_BYTE_LAST: begin
								count_q <= count_q + 61'd1;
								rnd_q <= '0;
								if (pos == 6'd63) begin
									state_q <= ST_ROUND;
									ret_q <= ST_PAD;
								end else begin
									state_q <= ST_PAD;
								end
							end
							default: begin
								state_q <= ST_PAD;
							end
						endcase
					end
				end
				ST_PAD: begin
					state_q <= ST_ROUND;
					rnd_q <= '0;
					ret_q <= pad_two ? ST_LEN : ST_OUT;
				end
				ST_LEN: begin
					state_q <= ST_ROUND;
					rnd_q <= '0;
					ret_q <= ST_OUT;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					chain_q.a <= chain_q.a + work_q.a;
					chain_q.b <= chain_q.b + work_q.b;
					chain_q.c <= chain_q.c + work_q.c;
					chain_q.d <= chain_q.d + work_q.d;
					out_idx_q <= '0;
					state_q <= ret_q;
				end
				ST_OUT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						out_idx_q <= out_idx_q + 4'd1;
						// The last digest byte is already in the output register,
						// so the chain can restart for the next message.
						if (out_idx_q == 4'd15) begin
							chain_q <= ChainInit;
							count_q <= '0;
							state_q <= ST_ABSORB;
						end
					end
				end
				default: begin
					state_q <= ST_ABSORB;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_byte_q <= out_word[{out_idx_q[1:0], 3'b000} +: 8];
			out_last_q <= (out_idx_q == 4'd15);
		end
		if (state_q == ST_ROUND) begin
			work_q <= work_next;
		end else begin
			work_q <= chain_q;
		end
		case (state_q)
			ST_ABSORB: begin
				if (take && (item.kind != KIND_LAST)) begin
					block_q[pad_w][{lane, 3'b000} +: 8] <= item.data;
				end
			end
			ST_PAD: begin
				for (int i = 0; i < 16; i++) begin
					if (4'(i) == pad_w) begin
						block_q[i] <= pad_word;
					end else if (4'(i) > pad_w) begin
						block_q[i] <= '0;
					end
				end
				if (!pad_two) begin
					block_q[14] <= len_bits[31:0];
					block_q[15] <= len_bits[63:32];
				end
			end
			ST_LEN: begin
				for (int i = 0; i < 14; i++) begin
					block_q[i] <= '0;
				end
				block_q[14] <= len_bits[31:0];
				block_q[15] <= len_bits[63:32];
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/md5_digest_stream.sv -----
// Channel   Direction  tdata            tuser          tlast
// s_axis    in         data_byte[7:0]   byte_present   last
// m_axis    out        digest_byte[7:0] -              digest_last
//
// The input queue takes an item every cycle while it has room; the back end absorbs one
// byte per cycle while in ST_ABSORB. Every 64th byte starts 64 rounds (one per cycle)
// and then an add into the chaining words. A last item adds a fill state, a compression
// and the 16 digest bytes; with 56 or more bytes in the final block the length spills
// into a second block, which adds the ST_LEN state and one more compression. An m_axis
// stall holds only the back end while the queue fills. Reset loads the chaining words.
module md5_digest_stream import md5_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tuser,   // [0] byte_present
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] digest_byte
	output logic       m_axis_tlast
);

	logic      item_valid;
	logic      item_ready;
	md5_item_t item;

	md5_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.in_present (s_axis_tuser),
		.in_last    (s_axis_tlast),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	md5_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.digest_valid (m_axis_tvalid),
		.digest_ready (m_axis_tready),
		.digest_byte  (m_axis_tdata),
		.digest_last  (m_axis_tlast)
	);

endmodule

// ----- hdl/md5_digest_stream_chk.sv -----
module md5_digest_stream_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tuser,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	logic [3:0] out_cnt_q;
	logic       out_take;

	assign out_take = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (out_take) begin
			out_cnt_q <= out_cnt_q + 4'd1;
		end
	end

	// A digest is always sixteen items with the mark on the last one only.
	a_last_on_sixteenth: assert property (@(posedge clk) disable iff (!arst_n)
		out_take |-> (m_axis_tlast == (out_cnt_q == 4'd15)))
		else $error("digest_last out of place");

	a_gap_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && m_axis_tlast) |=> !m_axis_tvalid)
		else $error("output valid right after a digest ended");

	a_no_output_in_reset: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("stalled output item changed");

endmodule

bind md5_digest_stream md5_digest_stream_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- test/tb.sv -----
module tb;
	import md5_pkg::*;

	localparam int QuietLimit = 5000;
	localparam int LongHoldCycles = 400;
	localparam int RandomItemTarget = 160;
	localparam int TailCycles = 200;

	localparam logic [31:0] RoundConst [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int RoundShift [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	typedef struct packed {
		logic [7:0] digest_byte;
		logic       digest_last;
	} digest_entry_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tuser;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	// Digest model state.
	logic [31:0] md5_chain [4];
	logic [31:0] md5_block [16];
	logic [60:0] md5_byte_count;

	digest_entry_t pending_digest [$];

	int error_count = 0;
	int quiet_cycles = 0;
	int random_items = 0;
	bit sender_gaps = 1'b1;
	bit sink_stalls = 1'b1;
	bit long_hold_req = 1'b0;
	bit long_hold_active = 1'b0;

	md5_digest_stream u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void md5_restart();
		md5_chain[0] = 32'h67452301;
		md5_chain[1] = 32'hefcdab89;
		md5_chain[2] = 32'h98badcfe;
		md5_chain[3] = 32'h10325476;
		md5_byte_count = '0;
	endfunction

	function automatic void md5_compress();
		logic [31:0] a, b, c, d, f, t, x;
		int r, g, s;
		a = md5_chain[0];
		b = md5_chain[1];
		c = md5_chain[2];
		d = md5_chain[3];
		for (r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			s = RoundShift[(r / 16) * 4 + r % 4];
			x = a + f + RoundConst[r] + md5_block[g];
			t = d;
			d = c;
			c = b;
			b = b + ((x << s) | (x >> (32 - s)));
			a = t;
		end
		md5_chain[0] += a;
		md5_chain[1] += b;
		md5_chain[2] += c;
		md5_chain[3] += d;
	endfunction

	// Absorbs one accepted item; a last item queues the 16 digest bytes.
	function automatic void md5_absorb(input logic [7:0] data, input logic present,
			input logic last);
		logic [5:0] pos;
		logic [63:0] bit_len;
		int w, lane, i;
		if (present) begin
			pos = md5_byte_count[5:0];
			w = pos[5:2];
			lane = pos[1:0];
			md5_block[w][8 * lane +: 8] = data;
			md5_byte_count = md5_byte_count + 61'd1;
			if (md5_byte_count[5:0] == 6'd0)
				md5_compress();
		end
		if (last) begin
			pos = md5_byte_count[5:0];
			w = pos[5:2];
			lane = pos[1:0];
			for (i = lane; i < 4; i++)
				md5_block[w][8 * i +: 8] = (i == lane) ? 8'h80 : 8'h00;
			for (i = w + 1; i < 16; i++)
				md5_block[i] = '0;
			// No room left for the length, so the padding spills into a second block.
			if (pos >= 6'd56) begin
				md5_compress();
				for (i = 0; i < 16; i++)
					md5_block[i] = '0;
			end
			bit_len = {md5_byte_count, 3'b000};
			md5_block[14] = bit_len[31:0];
			md5_block[15] = bit_len[63:32];
			md5_compress();
			for (i = 0; i < 16; i++)
				pending_digest.insert(pending_digest.size(),
					digest_entry_t'{md5_chain[i / 4][8 * (i % 4) +: 8], i == 15});
			md5_restart();
		end
	endfunction

	task automatic send_item(input logic [7:0] data, input logic present, input logic last);
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= present;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		md5_absorb(data, present, last);
		if (present || last)
			random_items++;
	endtask

	// Sends a message of len bytes. The end mark rides on the final byte or
	// comes as a separate item without a byte; with noise, empty items are mixed in.
	task automatic send_message(input int len, input bit last_on_byte, input bit noise);
		int i;
		for (i = 0; i < len; i++) begin
			if (noise && $urandom_range(0, 15) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, last_on_byte && i == len - 1);
		end
		if (!last_on_byte || len == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_for_digests();
		while (pending_digest.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_message();
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'ha5, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h5a, 1'b0, 1'b1);
	endtask

	task automatic test_short_messages();
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'h5a, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'ha5, 1'b1, 1'b0);
		send_item(8'h3c, 1'b0, 1'b1);
	endtask

	task automatic test_random_messages();
		int sel, len;
		int edge_lens [11] = '{55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128};
		random_items = 0;
		while (random_items < RandomItemTarget) begin
			sel = $urandom_range(0, 99);
			if (sel < 55)
				len = $urandom_range(0, 16);
			else if (sel < 85)
				len = edge_lens[$urandom_range(0, 10)];
			else
				len = $urandom_range(17, 200);
			send_message(len, 1'($urandom_range(0, 1)), 1'b1);
		end
	endtask

	// The sink holds off while a long message follows a short one, so the
	// pending digest blocks the back end and the input queue fills up.
	task automatic test_output_backpressure();
		s_axis_tvalid <= 1'b0;
		long_hold_req = 1'b1;
		@(posedge clk);
		while (!long_hold_active)
			@(posedge clk);
		send_message(3, 1'b1, 1'b0);
		send_message(100, 1'b1, 1'b0);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (long_hold_active)
			@(posedge clk);
	endtask

	task automatic test_pause_between_messages();
		send_message(20, 1'b0, 1'b0);
		s_axis_tvalid <= 1'b0;
		wait_for_digests();
		send_message(9, 1'b1, 1'b0);
	endtask

	task automatic test_full_rate();
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		send_message(64, 1'b1, 1'b0);
		send_message(1, 1'b1, 1'b0);
		send_message(0, 1'b0, 1'b0);
		send_message(70, 1'b0, 1'b0);
		send_message(56, 1'b1, 1'b0);
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		s_axis_tuser <= 1'b0;
		s_axis_tlast <= 1'b0;
		md5_restart();
		for (int i = 0; i < 16; i++)
			md5_block[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_message();
		test_short_messages();
		test_random_messages();
		test_output_backpressure();
		test_pause_between_messages();
		test_full_rate();
		s_axis_tvalid <= 1'b0;
		wait_for_digests();
		repeat (TailCycles) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Sink side: random short stalls, plus one long hold on request.
	initial begin
		forever begin
			if (long_hold_req) begin
				m_axis_tready <= 1'b0;
				long_hold_active = 1'b1;
				repeat (LongHoldCycles) @(posedge clk);
				long_hold_req = 1'b0;
				long_hold_active = 1'b0;
			end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		digest_entry_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_digest.size() == 0) begin
				$error("unexpected digest item: digest_byte %02h digest_last %0d",
					m_axis_tdata, m_axis_tlast);
				error_count++;
			end else begin
				want = pending_digest.pop_front();
				if (m_axis_tdata !== want.digest_byte) begin
					$error("digest_byte mismatch: expected %02h, actual %02h",
						want.digest_byte, m_axis_tdata);
					error_count++;
				end
				if (m_axis_tlast !== want.digest_last) begin
					$error("digest_last mismatch: expected %0d, actual %0d",
						want.digest_last, m_axis_tlast);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QuietLimit) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule

// ----- sim.f -----
hdl/md5_pkg.sv
hdl/md5_front.sv
hdl/md5_round.sv
hdl/md5_back.sv
hdl/md5_digest_stream.sv
hdl/md5_digest_stream_chk.sv
test/tb.sv
